@@ src/ma_pkg.sv @@
package ma_pkg;

   // Capacity of the held-note list.
   localparam int MAX_HELD = 16;
   localparam int IDX_W    = $clog2(MAX_HELD);
   localparam int CNT_W    = $clog2(MAX_HELD + 1);
   localparam int REM_W    = CNT_W + 1;

   localparam int NOTE_W = 7;

   // Galois LFSR used for the random pattern.
   localparam int              LFSR_W    = 16;
   localparam int              BIT_W     = $clog2(LFSR_W);
   localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
   localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

   localparam logic MSG_OFF = 1'b0;
   localparam logic MSG_ON  = 1'b1;

   typedef enum logic [1:0] {
      REQ_NOTE_ON  = 2'd0,
      REQ_NOTE_OFF = 2'd1,
      REQ_TICK     = 2'd2,
      REQ_CLEAR    = 2'd3
   } ma_req_type;

   typedef enum logic [1:0] {
      PAT_UP       = 2'd0,
      PAT_DOWN     = 2'd1,
      PAT_PINGPONG = 2'd2,
      PAT_RANDOM   = 2'd3
   } ma_pat_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_RM_RD,
      ST_RM_CMP,
      ST_TK_OFF,
      ST_TK_ON,
      ST_SR_RD,
      ST_SR_CMP,
      ST_SEL,
      ST_DIV,
      ST_RND_FIX,
      ST_PK_RD,
      ST_PK_WAIT
   } ma_state_type;

   // One outgoing MIDI message offered by the sequencer.
   typedef struct packed {
      logic              vld;
      logic              kind;
      logic [NOTE_W-1:0] note;
      logic              last;
   } ma_msg_type;

   // Write and read access to the held-note memory.
   typedef struct packed {
      logic              we;
      logic [IDX_W-1:0]  waddr;
      logic [NOTE_W-1:0] wdata;
      logic [IDX_W-1:0]  raddr;
   } ma_ram_req_type;

   // Sequencer status seen by the top level.
   typedef struct packed {
      logic             idle;
      logic [CNT_W-1:0] count;
   } ma_stat_type;

endpackage

@@ src/ma_ram.sv @@
module ma_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/ma_ctrl.sv @@
module ma_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic [1:0]                 req_type,
   input  logic [ma_pkg::NOTE_W-1:0]  req_note,
   input  logic                       csr_wr_en,
   input  logic [1:0]                 csr_wr_data,
   input  logic                       out_free,
   input  logic [ma_pkg::NOTE_W-1:0]  rd_data,
   output ma_pkg::ma_stat_type        stat,
   output ma_pkg::ma_msg_type         emit,
   output ma_pkg::ma_ram_req_type     ram_req
);

   import ma_pkg::*;

   ma_state_type      state_ff,    state_in;
   ma_pat_type        mode_ff,     mode_in;
   logic [CNT_W-1:0]  count_ff,    count_in;
   logic [NOTE_W-1:0] sounding_ff, sounding_in;
   logic [NOTE_W-1:0] pending_ff,  pending_in;
   logic              up_ff,       up_in;
   logic [LFSR_W-1:0] lfsr_ff,     lfsr_in;
   logic [NOTE_W-1:0] note_ff,     note_in;
   logic [CNT_W-1:0]  idx_ff,      idx_in;
   logic [CNT_W-1:0]  wr_ff,       wr_in;
   logic [CNT_W-1:0]  pos_ff,      pos_in;
   logic              found_ff,    found_in;
   logic [REM_W-1:0]  rem_ff,      rem_in;
   logic [BIT_W-1:0]  bit_ff,      bit_in;

   logic [CNT_W-1:0]  idx_m1, idx_p1, pos_m1, pos_p1, n_m1, rem_c, rem_p1;
   logic [REM_W-1:0]  rem_sh, n_ext;
   logic [LFSR_W-1:0] lfsr_step;

   assign idx_m1    = idx_ff - CNT_W'(1);
   assign idx_p1    = idx_ff + CNT_W'(1);
   assign pos_m1    = pos_ff - CNT_W'(1);
   assign pos_p1    = pos_ff + CNT_W'(1);
   assign n_m1      = count_ff - CNT_W'(1);
   assign n_ext     = {1'b0, count_ff};
   assign rem_sh    = {rem_ff[REM_W-2:0], lfsr_ff[bit_ff]};
   assign rem_c     = rem_ff[CNT_W-1:0];
   assign rem_p1    = rem_c + CNT_W'(1);
   assign lfsr_step = {1'b0, lfsr_ff[LFSR_W-1:1]} ^ (lfsr_ff[0] ? LFSR_TAPS : '0);

   assign stat.idle  = (state_ff == ST_IDLE);
   assign stat.count = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         mode_ff     <= PAT_UP;
         count_ff    <= '0;
         sounding_ff <= '0;
         pending_ff  <= '0;
         up_ff       <= 1'b1;
         lfsr_ff     <= LFSR_SEED;
      end else begin
         state_ff    <= state_in;
         mode_ff     <= mode_in;
         count_ff    <= count_in;
         sounding_ff <= sounding_in;
         pending_ff  <= pending_in;
         up_ff       <= up_in;
         lfsr_ff     <= lfsr_in;
      end
      note_ff  <= note_in;
      idx_ff   <= idx_in;
      wr_ff    <= wr_in;
      pos_ff   <= pos_in;
      found_ff <= found_in;
      rem_ff   <= rem_in;
      bit_ff   <= bit_in;
   end

   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      count_in    = count_ff;
      sounding_in = sounding_ff;
      pending_in  = pending_ff;
      up_in       = up_ff;
      lfsr_in     = lfsr_ff;
      note_in     = note_ff;
      idx_in      = idx_ff;
      wr_in       = wr_ff;
      pos_in      = pos_ff;
      found_in    = found_ff;
      rem_in      = rem_ff;
      bit_in      = bit_ff;
      ram_req     = '0;
      emit        = '0;

      if (csr_wr_en) begin
         mode_in = ma_pat_type'(csr_wr_data);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (ma_req_type'(req_type))
                  REQ_NOTE_ON: begin
                     if (req_note != '0) begin
                        if (pending_ff == '0) begin
                           pending_in = req_note;
                        end
                        if (count_ff < CNT_W'(MAX_HELD)) begin
                           note_in  = req_note;
                           idx_in   = count_ff;
                           state_in = ST_INS_RD;
                        end
                     end
                  end
                  REQ_NOTE_OFF: begin
                     if (req_note != '0) begin
                        note_in  = req_note;
                        idx_in   = '0;
                        wr_in    = '0;
                        state_in = ST_RM_RD;
                     end
                  end
                  REQ_TICK: begin
                     state_in = ST_TK_OFF;
                  end
                  REQ_CLEAR: begin
                     count_in    = '0;
                     sounding_in = '0;
                     pending_in  = '0;
                  end
               endcase
            end
         end

         // Insertion sort step: shift larger entries up by one slot.
         ST_INS_RD: begin
            if (idx_ff == '0) begin
               ram_req.we    = 1'b1;
               ram_req.waddr = idx_ff[IDX_W-1:0];
               ram_req.wdata = note_ff;
               count_in      = count_ff + CNT_W'(1);
               state_in      = ST_IDLE;
            end else begin
               ram_req.raddr = idx_m1[IDX_W-1:0];
               state_in      = ST_INS_CMP;
            end
         end
         ST_INS_CMP: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = idx_ff[IDX_W-1:0];
            if (rd_data > note_ff) begin
               ram_req.wdata = rd_data;
               idx_in        = idx_m1;
               state_in      = ST_INS_RD;
            end else begin
               ram_req.wdata = note_ff;
               count_in      = count_ff + CNT_W'(1);
               state_in      = ST_IDLE;
            end
         end

         // Compaction: copy every entry that differs from the note downward.
         ST_RM_RD: begin
            if (idx_ff == count_ff) begin
               count_in = wr_ff;
               state_in = ST_IDLE;
            end else begin
               ram_req.raddr = idx_ff[IDX_W-1:0];
               state_in      = ST_RM_CMP;
            end
         end
         ST_RM_CMP: begin
            if (rd_data != note_ff) begin
               ram_req.we    = 1'b1;
               ram_req.waddr = wr_ff[IDX_W-1:0];
               ram_req.wdata = rd_data;
               wr_in         = wr_ff + CNT_W'(1);
            end
            idx_in   = idx_p1;
            state_in = ST_RM_RD;
         end

         ST_TK_OFF: begin
            if (sounding_ff != '0) begin
               emit.vld  = 1'b1;
               emit.kind = MSG_OFF;
               emit.note = sounding_ff;
               emit.last = (count_ff == '0);
            end
            if (sounding_ff == '0 || out_free) begin
               if (count_ff == '0) begin
                  sounding_in = '0;
                  pending_in  = '0;
                  state_in    = ST_IDLE;
               end else begin
                  state_in = ST_TK_ON;
               end
            end
         end
         ST_TK_ON: begin
            emit.vld  = 1'b1;
            emit.kind = MSG_ON;
            emit.note = pending_ff;
            emit.last = 1'b1;
            if (out_free) begin
               sounding_in = pending_ff;
               if (count_ff == CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = '0;
                  found_in = 1'b0;
                  state_in = ST_SR_RD;
               end
            end
         end

         // Find the first copy of the sounding note.
         ST_SR_RD: begin
            if (idx_ff == count_ff) begin
               state_in = ST_SEL;
            end else begin
               ram_req.raddr = idx_ff[IDX_W-1:0];
               state_in      = ST_SR_CMP;
            end
         end
         ST_SR_CMP: begin
            if (rd_data == sounding_ff) begin
               pos_in   = idx_ff;
               found_in = 1'b1;
               state_in = ST_SEL;
            end else begin
               idx_in   = idx_p1;
               state_in = ST_SR_RD;
            end
         end

         ST_SEL: begin
            state_in = ST_PK_RD;
            unique case (mode_ff)
               PAT_UP: begin
                  idx_in = (found_ff && pos_p1 < count_ff) ? pos_p1 : '0;
               end
               PAT_DOWN: begin
                  idx_in = (found_ff && pos_ff != '0) ? pos_m1 : n_m1;
               end
               PAT_PINGPONG: begin
                  if (up_ff) begin
                     if (!found_ff) begin
                        idx_in = '0;
                     end else if (pos_p1 < count_ff) begin
                        idx_in = pos_p1;
                     end else begin
                        up_in  = 1'b0;
                        idx_in = pos_m1;
                     end
                  end else begin
                     if (found_ff && pos_ff != '0) begin
                        idx_in = pos_m1;
                     end else begin
                        up_in  = 1'b1;
                        idx_in = found_ff ? pos_p1 : '0;
                     end
                  end
               end
               PAT_RANDOM: begin
                  lfsr_in  = lfsr_step;
                  rem_in   = '0;
                  bit_in   = BIT_W'(LFSR_W - 1);
                  state_in = ST_DIV;
               end
            endcase
         end

         // Restoring remainder of the LFSR value by the list length, MSB first.
         ST_DIV: begin
            rem_in = (rem_sh >= n_ext) ? rem_sh - n_ext : rem_sh;
            bit_in = bit_ff - BIT_W'(1);
            if (bit_ff == '0) begin
               state_in = ST_RND_FIX;
            end
         end
         ST_RND_FIX: begin
            if (found_ff && rem_c == pos_ff) begin
               idx_in = (rem_p1 == count_ff) ? '0 : rem_p1;
            end else begin
               idx_in = rem_c;
            end
            state_in = ST_PK_RD;
         end

         ST_PK_RD: begin
            ram_req.raddr = idx_ff[IDX_W-1:0];
            state_in      = ST_PK_WAIT;
         end
         ST_PK_WAIT: begin
            pending_in = rd_data;
            state_in   = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ src/midi_arpeggiator.sv @@
// MIDI arpeggiator. The block holds up to MAX_HELD (16) notes in a sorted list kept in
// a memory with one write port and one registered read port; note-on items insert a
// copy, note-off items remove every copy, and clear items empty the list. Each metronome
// tick item produces a note-off for the sounding note (if any) and, while notes are held,
// a note-on for the pending note; the following pending note is then chosen by the
// pattern register (ascending, descending, ping-pong, or random from a 16-bit LFSR).
// Items are taken one at a time; each list step reads the memory and compares and writes
// in the state after that read, as the read port is registered. A note-on and a note-off
// walk the list, a clear needs no list walk, and a tick walks the list to find the
// sounding note, adds a bit-serial remainder and a repeat check in random mode, and
// stalls while the output register is full. A finished result waits in an output
// register, so the next item is accepted while it is still unread.
// The pattern register may only be written while the block is idle.
module midi_arpeggiator (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_type,
   input  logic [ma_pkg::NOTE_W-1:0]  req_note,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_msg_kind,
   output logic [ma_pkg::NOTE_W-1:0]  rsp_out_note,
   output logic                       rsp_last,
   input  logic                       csr_wr_en,
   input  logic [1:0]                 csr_wr_data
);

   import ma_pkg::*;

   ma_stat_type     stat;
   ma_msg_type      emit;
   ma_ram_req_type  ram_req;
   logic [NOTE_W-1:0] rd_data;
   logic            out_free;
   logic            push;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_kind_ff;
   logic [NOTE_W-1:0] rsp_note_ff;
   logic              rsp_last_ff;

   // The sequencer walks the held-note list; each step issues one memory read and writes
   // back, where needed, in the state after that read, once the read data is back.
   ma_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_type    (req_type),
      .req_note    (req_note),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .out_free    (out_free),
      .rd_data     (rd_data),
      .stat        (stat),
      .emit        (emit),
      .ram_req     (ram_req)
   );

   ma_ram #(
      .WIDTH (NOTE_W),
      .DEPTH (MAX_HELD)
   ) u_notes (
      .clock   (clock),
      .wr_en   (ram_req.we),
      .wr_addr (ram_req.waddr),
      .wr_data (ram_req.wdata),
      .rd_addr (ram_req.raddr),
      .rd_data (rd_data)
   );

   assign req_ready = stat.idle;

   // The output register can take a new item when empty or when its item leaves now.
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign push     = emit.vld && out_free;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (push) begin
         rsp_kind_ff <= emit.kind;
         rsp_note_ff <= emit.note;
         rsp_last_ff <= emit.last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_msg_kind = rsp_kind_ff;
   assign rsp_out_note = rsp_note_ff;
   assign rsp_last     = rsp_last_ff;

   // A note-on message is always the final item of its tick.
   a_on_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_msg_kind == MSG_ON) |-> rsp_last)
      else $error("note-on item without last flag");

   // Only tick items may lead to an offered message in the following cycle.
   a_no_msg_after_note: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_type != REQ_TICK) |=> !emit.vld)
      else $error("message offered after a non-tick item");

   // The held count never exceeds the list capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      stat.count <= CNT_W'(MAX_HELD))
      else $error("held note count out of range");

   // A message is only offered while the sequencer is busy with a tick.
   a_emit_busy: assert property (@(posedge clock) disable iff (reset)
      emit.vld |-> !stat.idle)
      else $error("message offered while idle");

endmodule
